// ===== rtl/mip_pyramid_trilinear_sampler_assert.svh =====
// Assertion macros for the mip pyramid trilinear sampler.
// Used by the top level; expects clk and arst_n in the enclosing module.
`ifndef MIP_PYRAMID_TRILINEAR_SAMPLER_ASSERT_SVH
`define MIP_PYRAMID_TRILINEAR_SAMPLER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication checked at every rising clock edge outside reset.
`define MPTS_ASSERT_SAME(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error(msg);
// Next-cycle implication checked at every rising clock edge outside reset.
`define MPTS_ASSERT_NEXT(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error(msg);
`else
`define MPTS_ASSERT_SAME(lbl, pre, con, msg)
`define MPTS_ASSERT_NEXT(lbl, pre, con, msg)
`endif
`endif

// ===== rtl/mpts_pkg.sv =====
// Shared types and codes of the mip pyramid trilinear sampler.
// No dependencies; imported by every module of the block.
`default_nettype none
package mpts_pkg;

	// Action codes of an input item.
	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_BUILD  = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	// Wrap modes; any other code means black outside the level.
	localparam logic [1:0] WRAP_REPEAT = 2'd0;
	localparam logic [1:0] WRAP_CLAMP  = 2'd1;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_WRITE = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WRAP   = 2'd0;
	localparam logic [1:0] CFG_LOG2_W = 2'd1;
	localparam logic [1:0] CFG_LOG2_H = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         write_col;
		logic [7:0]         write_row;
		logic [15:0]        texel_value;
		logic signed [23:0] s_coord;
		logic signed [23:0] t_coord;
		logic [16:0]        filter_width;
	} mpts_in_t;

	typedef struct packed {
		logic [15:0] sample_value;
		logic [1:0]  status;
	} mpts_out_t;

	typedef struct packed {
		logic [1:0] wrap;
		logic [3:0] lw;
		logic [3:0] lh;
	} mpts_cfg_t;

	// Classified item as it waits in the queue.
	typedef struct packed {
		mpts_in_t    item;
		logic        wr_bad;
		logic [4:0]  lg_e;
		logic [16:0] lg_x;
	} mpts_job_t;

	// Back end status seen by the front end and the top level.
	typedef struct packed {
		logic ready;
		logic pyr_ready;
	} mpts_bstat_t;

endpackage
`default_nettype wire

// ===== rtl/mip_pyramid_trilinear_sampler.sv =====
// Top level of the mip pyramid trilinear sampler: configuration registers,
// front end queue and back end sequencer. Depends on mpts_pkg, mpts_front, mpts_back.
//
//  Channel   Ports                                 Transfer
//  input     start, busy, item                     start high and busy low at a clock edge
//  result    done, result                          done high for one cycle, always taken
//  config    cfg_write, cfg_index, cfg_data        cfg_write high at a clock edge
//
// A base write, a lookup before build or an unused action is finished in the idle state.
// A lookup runs 8 log2 rounds and a decode step, then filters one or two levels
// bilinearly and blends them, or reads the top texel alone, through the single
// store read port. A build averages four texels per texel of every level above the base.
// The queue holds two items; busy rises when it is full. Reset does not touch the
// texel store, which holds unknown values until written.
`default_nettype none
`include "mip_pyramid_trilinear_sampler_assert.svh"
module mip_pyramid_trilinear_sampler #(
	parameter int MAX_LOG2_SIZE = 8,
	parameter int TEXEL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mpts_pkg::mpts_in_t  item,
	output logic                done,
	output mpts_pkg::mpts_out_t result,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data
);
	import mpts_pkg::*;

	localparam logic [3:0] MAX_L2 = 4'(MAX_LOG2_SIZE);
	localparam logic [3:0] RST_L2 = (MAX_LOG2_SIZE < 8) ? MAX_L2 : 4'd8;

	mpts_cfg_t   cfg_q;
	mpts_job_t   job;
	mpts_bstat_t bstat;
	logic        job_valid;
	logic        pyr_clear;
	logic [3:0]  l2_sat;

	assign l2_sat = (cfg_data > MAX_L2) ? MAX_L2 : cfg_data;
	assign pyr_clear = cfg_write && (cfg_index == CFG_LOG2_W || cfg_index == CFG_LOG2_H);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrap <= WRAP_REPEAT;
			cfg_q.lw <= RST_L2;
			cfg_q.lh <= RST_L2;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WRAP: begin
					cfg_q.wrap <= cfg_data[1:0];
				end
				CFG_LOG2_W: begin
					cfg_q.lw <= l2_sat;
				end
				CFG_LOG2_H: begin
					cfg_q.lh <= l2_sat;
				end
				default: begin
				end
			endcase
		end
	end

	mpts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg       (cfg_q),
		.bstat     (bstat),
		.job_valid (job_valid),
		.job       (job)
	);

	mpts_back #(
		.MAX_LOG2_SIZE (MAX_LOG2_SIZE),
		.TEXEL_BITS    (TEXEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pyr_clear (pyr_clear),
		.job_valid (job_valid),
		.job       (job),
		.bstat     (bstat),
		.done      (done),
		.result    (result)
	);

	// A failed item never carries a sample.
	`MPTS_ASSERT_SAME(a_fail_no_sample, done && result.status != ST_OK, result.sample_value == 16'd0, "sample on failed item")
	// A size change always drops the built pyramid.
	`MPTS_ASSERT_NEXT(a_size_clears, pyr_clear, !bstat.pyr_ready, "pyramid kept after size change")

endmodule
`default_nettype wire

// ===== rtl/mpts_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on mpts_pkg.
`default_nettype none
module mpts_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mpts_pkg::mpts_in_t    item,
	input  mpts_pkg::mpts_cfg_t   cfg,
	input  mpts_pkg::mpts_bstat_t bstat,
	output logic                  job_valid,
	output mpts_pkg::mpts_job_t   job
);
	import mpts_pkg::*;

	mpts_job_t   slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	mpts_job_t   new_job;
	logic [16:0] w_eff;
	logic [4:0]  e;
	logic        push;
	logic        pop;

	// Classify: write bounds and the normalized filter width.
	always_comb begin
		w_eff = (item.filter_width == 17'd0) ? 17'd1 : item.filter_width;
		e = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (w_eff[i]) begin
				e = 5'(i);
			end
		end
		new_job.item = item;
		new_job.wr_bad = ((16'(item.write_col) >> cfg.lw) != 16'd0) ||
			((16'(item.write_row) >> cfg.lh) != 16'd0);
		new_job.lg_e = e;
		new_job.lg_x = 17'(w_eff << (5'd16 - e));
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid && bstat.ready;
	assign job = slot_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_job;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mpts_back.sv =====
// Back end: texel store, pyramid build sequencer and filtered lookup sequencer.
// Depends on mpts_pkg.
`default_nettype none
module mpts_back #(
	parameter int MAX_LOG2_SIZE = 8,
	parameter int TEXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpts_pkg::mpts_cfg_t   cfg,
	input  logic                  pyr_clear,
	input  logic                  job_valid,
	input  mpts_pkg::mpts_job_t   job,
	output mpts_pkg::mpts_bstat_t bstat,
	output logic                  done,
	output mpts_pkg::mpts_out_t   result
);
	import mpts_pkg::*;

	localparam int M = MAX_LOG2_SIZE;
	localparam int TB = TEXEL_BITS;
	localparam int DEPTH = ((1 << (2 * (M + 1))) - 1) / 3;
	localparam int AW = $clog2(DEPTH);
	localparam int LVW = $clog2(M + 1);
	localparam int CW = M + 10;
	localparam int UW = M + 25;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_BUILD = 8'b00000010,
		S_LSEL = 8'b00000100,
		S_LDEC = 8'b00001000,
		S_LSET = 8'b00010000,
		S_LCOR = 8'b00100000,
		S_TOP = 8'b01000000,
		S_TOPW = 8'b10000000
	} state_t;

	typedef struct packed {
		logic          black;
		logic [AW-1:0] addr;
	} fetch_t;

	// Size exponent of a level along one axis.
	function automatic logic [4:0] lvl_l(input logic [3:0] l2, input logic [LVW-1:0] lv);
		return (5'(l2) > 5'(lv)) ? 5'(l2) - 5'(lv) : 5'd0;
	endfunction

	// Start of a level in the store; level sizes are distinct powers of two.
	function automatic logic [AW-1:0] lvl_off(input logic [3:0] lw, input logic [3:0] lh,
		input logic [LVW-1:0] lv);
		logic [AW-1:0] off;
		logic [4:0]    ew;
		logic [4:0]    eh;
		off = '0;
		for (int k = 0; k <= M; k++) begin
			ew = (5'(lw) > 5'(k)) ? 5'(lw) - 5'(k) : 5'd0;
			eh = (5'(lh) > 5'(k)) ? 5'(lh) - 5'(k) : 5'd0;
			if (k < int'(lv)) begin
				off = off | (AW'(1) << (6'(ew) + 6'(eh)));
			end
		end
		return off;
	endfunction

	// Applies the wrap mode to a texel position and forms its store address.
	function automatic fetch_t wrap_fetch(input logic [1:0] mode, input logic [3:0] lw,
		input logic [3:0] lh, input logic [LVW-1:0] lv,
		input logic signed [CW-1:0] col, input logic signed [CW-1:0] row);
		logic [4:0]           ew;
		logic [4:0]           eh;
		logic signed [CW-1:0] wv;
		logic signed [CW-1:0] hv;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] r;
		logic                 outside;
		fetch_t               f;
		ew = lvl_l(lw, lv);
		eh = lvl_l(lh, lv);
		wv = $signed(CW'(1) << ew);
		hv = $signed(CW'(1) << eh);
		outside = (col < 0) || (col >= wv) || (row < 0) || (row >= hv);
		case (mode)
			WRAP_REPEAT: begin
				c = col & (wv - 1);
				r = row & (hv - 1);
			end
			WRAP_CLAMP: begin
				c = (col < 0) ? '0 : ((col >= wv) ? wv - 1 : col);
				r = (row < 0) ? '0 : ((row >= hv) ? hv - 1 : row);
			end
			default: begin
				c = col;
				r = row;
			end
		endcase
		f.black = (mode != WRAP_REPEAT) && (mode != WRAP_CLAMP) && outside;
		f.addr = lvl_off(lw, lh, lv) + ((AW'($unsigned(r)) << ew) | AW'($unsigned(c)));
		return f;
	endfunction

	logic [TB-1:0]        mem [DEPTH];
	state_t               state_q;
	mpts_job_t            job_q;
	logic [LVW-1:0]       lv_q;
	logic [M-1:0]         col_q;
	logic [M-1:0]         row_q;
	logic [2:0]           p_q;
	logic [TB+1:0]        sum_q;
	logic [16:0]          x_q;
	logic [7:0]           f_q;
	logic [2:0]           k_q;
	logic [LVW-1:0]       cur_lv_q;
	logic [7:0]           d_q;
	logic                 two_q;
	logic                 first_q;
	logic signed [CW-1:0] u0_q;
	logic signed [CW-1:0] v0_q;
	logic [15:0]          ds_q;
	logic [15:0]          dt_q;
	logic [32:0]          wgt_s1;
	logic [TB+32:0]       prod_s2;
	logic [TB+32:0]       acc_q;
	logic [TB+9:0]        blend_q;
	logic [TB-1:0]        rdata_q;
	logic                 black_s1;
	logic                 pyr_q;
	logic                 done_q;
	mpts_out_t            res_q;

	logic [3:0]           lmax;
	logic [LVW-1:0]       lmax_lv;
	logic [LVW-1:0]       f_lv;
	logic signed [CW-1:0] f_col;
	logic signed [CW-1:0] f_row;
	fetch_t               fetch;
	logic [TB-1:0]        eff;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [TB-1:0]        mem_wdata;
	logic [4:0]           bw_e;
	logic [4:0]           bh_e;
	logic                 col_last;
	logic                 row_last;
	logic [33:0]          sq;
	logic [17:0]          sq_h;
	logic signed [6:0]    hi;
	logic [4:0]           le_w;
	logic [4:0]           le_h;
	logic signed [UW-1:0] u;
	logic signed [UW-1:0] v;
	logic [16:0]          wx;
	logic [16:0]          wy;
	logic [33:0]          wgt;
	logic [TB-1:0]        bil;
	logic [8:0]           wl;
	logic [TB+9:0]        bsum;

	assign lmax = (cfg.lw > cfg.lh) ? cfg.lw : cfg.lh;
	assign lmax_lv = LVW'(lmax);
	assign eff = black_s1 ? '0 : rdata_q;

	// Position fed to the shared wrap and address unit.
	always_comb begin
		f_lv = cur_lv_q;
		f_col = u0_q + CW'(p_q[0]);
		f_row = v0_q + CW'(p_q[1]);
		case (state_q)
			S_BUILD: begin
				f_lv = lv_q - LVW'(1);
				f_col = $signed(CW'({col_q, p_q[0]}));
				f_row = $signed(CW'({row_q, p_q[1]}));
			end
			S_TOP: begin
				f_lv = lmax_lv;
				f_col = '0;
				f_row = '0;
			end
			default: begin
			end
		endcase
		fetch = wrap_fetch(cfg.wrap, cfg.lw, cfg.lh, f_lv, f_col, f_row);
	end

	// Build position within the current level.
	always_comb begin
		bw_e = lvl_l(cfg.lw, lv_q);
		bh_e = lvl_l(cfg.lh, lv_q);
		col_last = ((M + 1)'(col_q) + (M + 1)'(1)) == ((M + 1)'(1) << bw_e);
		row_last = ((M + 1)'(row_q) + (M + 1)'(1)) == ((M + 1)'(1) << bh_e);
	end

	// Store write port: base texel writes and built texels.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = (AW'(job.item.write_row) << cfg.lw) | AW'(job.item.write_col);
		mem_wdata = TB'(job.item.texel_value);
		if (state_q == S_IDLE) begin
			mem_we = job_valid && (job.item.action == ACT_WRITE) && !job.wr_bad;
		end else if (state_q == S_BUILD) begin
			mem_we = (p_q == 3'd4);
			mem_waddr = lvl_off(cfg.lw, cfg.lh, lv_q) +
				((AW'(row_q) << bw_e) | AW'(col_q));
			mem_wdata = TB'((sum_q + (TB + 2)'(eff)) >> 2);
		end
	end

	// Level select, bilinear setup, weights and blend arithmetic.
	always_comb begin
		sq = 34'(x_q) * 34'(x_q);
		sq_h = sq[33:16];
		hi = $signed({3'b000, lmax}) + $signed({2'b00, job_q.lg_e}) - 7'sd16;
		le_w = lvl_l(cfg.lw, cur_lv_q);
		le_h = lvl_l(cfg.lh, cur_lv_q);
		u = (UW'(job_q.item.s_coord) <<< le_w) - UW'(32768);
		v = (UW'(job_q.item.t_coord) <<< le_h) - UW'(32768);
		wx = p_q[0] ? {1'b0, ds_q} : 17'd65536 - {1'b0, ds_q};
		wy = p_q[1] ? {1'b0, dt_q} : 17'd65536 - {1'b0, dt_q};
		wgt = 34'(wx) * 34'(wy);
		bil = acc_q[TB+31:32];
		wl = first_q ? 9'd256 - 9'(d_q) : 9'(d_q);
		bsum = blend_q + (TB + 10)'(wl) * (TB + 10)'(bil);
	end

	// Texel store with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[fetch.addr];
		black_s1 <= fetch.black;
	end

	// Weight and product pipeline of the bilinear filter.
	always_ff @(posedge clk) begin
		wgt_s1 <= 33'(wgt);
		prod_s2 <= (TB + 33)'(wgt_s1) * (TB + 33)'(eff);
	end

	// Sequencer datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				job_q <= job;
				lv_q <= LVW'(1);
				col_q <= '0;
				row_q <= '0;
				x_q <= job.lg_x;
				f_q <= '0;
				k_q <= '0;
			end
			S_BUILD: begin
				if (p_q == 3'd1) begin
					sum_q <= (TB + 2)'(eff);
				end else if (p_q == 3'd2 || p_q == 3'd3) begin
					sum_q <= sum_q + (TB + 2)'(eff);
				end
				if (p_q == 3'd4) begin
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							row_q <= '0;
							lv_q <= lv_q + LVW'(1);
						end else begin
							row_q <= row_q + M'(1);
						end
					end else begin
						col_q <= col_q + M'(1);
					end
				end
			end
			S_LSEL: begin
				if (sq_h[17]) begin
					x_q <= sq_h[17:1];
					f_q[3'd7 - k_q] <= 1'b1;
				end else begin
					x_q <= sq_h[16:0];
				end
				k_q <= k_q + 3'd1;
			end
			S_LDEC: begin
				blend_q <= '0;
				first_q <= 1'b1;
				if (hi < 0) begin
					cur_lv_q <= '0;
					d_q <= '0;
					two_q <= 1'b0;
				end else if (hi >= $signed({3'b000, lmax})) begin
					cur_lv_q <= lmax_lv;
				end else begin
					cur_lv_q <= LVW'(hi);
					d_q <= f_q;
					two_q <= 1'b1;
				end
			end
			S_LSET: begin
				u0_q <= CW'($signed(u[UW-1:16]));
				v0_q <= CW'($signed(v[UW-1:16]));
				ds_q <= u[15:0];
				dt_q <= v[15:0];
			end
			S_LCOR: begin
				if (p_q == 3'd0) begin
					acc_q <= '0;
				end else if (p_q >= 3'd2 && p_q <= 3'd5) begin
					acc_q <= acc_q + prod_s2;
				end
				if (p_q == 3'd6) begin
					blend_q <= bsum;
					first_q <= 1'b0;
					cur_lv_q <= cur_lv_q + LVW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer control, pyramid flag and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q <= '0;
			pyr_q <= 1'b0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					p_q <= '0;
					if (job_valid) begin
						res_q.sample_value <= '0;
						res_q.status <= ST_OK;
						case (job.item.action)
							ACT_WRITE: begin
								done_q <= 1'b1;
								res_q.status <= job.wr_bad ? ST_BAD_WRITE : ST_OK;
							end
							ACT_BUILD: begin
								if (lmax == 4'd0) begin
									done_q <= 1'b1;
									pyr_q <= !pyr_clear;
								end else begin
									state_q <= S_BUILD;
								end
							end
							ACT_LOOKUP: begin
								if (pyr_q) begin
									state_q <= S_LSEL;
								end else begin
									done_q <= 1'b1;
									res_q.status <= ST_NOT_BUILT;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_BUILD: begin
					if (p_q == 3'd4) begin
						p_q <= '0;
						if (col_last && row_last && lv_q == lmax_lv) begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							pyr_q <= !pyr_clear;
						end
					end else begin
						p_q <= p_q + 3'd1;
					end
				end
				S_LSEL: begin
					if (k_q == 3'd7) begin
						state_q <= S_LDEC;
					end
				end
				S_LDEC: begin
					if (hi >= 0 && hi >= $signed({3'b000, lmax})) begin
						state_q <= S_TOP;
					end else begin
						state_q <= S_LSET;
					end
				end
				S_LSET: begin
					p_q <= '0;
					state_q <= S_LCOR;
				end
				S_LCOR: begin
					if (p_q == 3'd6) begin
						if (two_q && first_q) begin
							state_q <= S_LSET;
						end else begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							res_q.sample_value <= 16'(bsum[TB+7:8]);
						end
					end else begin
						p_q <= p_q + 3'd1;
					end
				end
				S_TOP: begin
					state_q <= S_TOPW;
				end
				S_TOPW: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					res_q.sample_value <= 16'(eff);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (pyr_clear) begin
				pyr_q <= 1'b0;
			end
		end
	end

	assign bstat.ready = (state_q == S_IDLE);
	assign bstat.pyr_ready = pyr_q;
	assign done = done_q;
	assign result = res_q;

endmodule
`default_nettype wire
